// File: rtl/bqpt_pkg.sv
package bqpt_pkg;
  localparam int NormScaleDef = 2048;
  localparam int SwingsDef = 4;
  localparam int NumRegs = 8;
  localparam logic signed [15:0] ResetLow = -16'sd4095;
  localparam logic signed [15:0] ResetHigh = 16'sd4095;

  typedef enum logic [2:0] {
    REG_B0 = 3'd0, REG_B1 = 3'd1, REG_B2 = 3'd2, REG_A1 = 3'd3,
    REG_A2 = 3'd4, REG_CENTER = 3'd5, REG_DELTA = 3'd6, REG_SPEED = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0, PH_UP = 2'd1, PH_DOWN = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_ACC, BK_TRACK, BK_DIV, BK_OUT
  } back_state_e;

  // queued beat between front and back
  typedef struct packed {
    logic signed [12:0] sample;
    logic               tracking;
  } item_t;

  typedef struct packed {
    logic signed [18:0] b0;
    logic signed [18:0] b1;
    logic signed [18:0] b2;
    logic signed [18:0] a1;
    logic signed [18:0] a2;
    logic signed [12:0] center;
    logic        [11:0] delta;
    logic        [15:0] speed_thr;
  } cfg_t;
endpackage

// File: rtl/bqpt_front.sv
module bqpt_front import bqpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [15:0] speed_thr_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output item_t       q_item_o
);
  // two-entry queue
  item_t      mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push;

  assign s_axis_tready = cnt_q != 2'd2;
  assign push = s_axis_tvalid && s_axis_tready;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_item_o = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].sample <= s_axis_tdata[12:0];
      mem_q[wp_q].tracking <= s_axis_tdata[28:13] <= speed_thr_i;
    end
  end
endmodule

// File: rtl/bqpt_div.sv
module bqpt_div #(
  parameter int W = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem_q, quo_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [W:0]    trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
  assign quo_o = quo_q;
  assign done_o = busy_q && cnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= CW'(W);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q && cnt_q != '0) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end
endmodule

// File: rtl/bqpt_back.sv
module bqpt_back import bqpt_pkg::*; #(
  parameter int NORM_SCALE = NormScaleDef,
  parameter int SWINGS_PER_WINDOW = SwingsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);
  localparam int LimV = 2 * NORM_SCALE;
  back_state_e st_q, st_d;
  logic signed [12:0] xh1_q, xh2_q, x0_q;
  logic signed [31:0] yh1_q, yh2_q;
  logic               trk_q;
  logic [2:0]         mi_q;
  logic signed [63:0] acc_q, prod_q;
  logic signed [31:0] y_q;
  logic signed [15:0] tlo_q, thi_q, plo_q, phi_q, plev_q;
  logic signed [16:0] mid_q, span_q;
  logic [3:0]         swc_q;
  phase_e             ph_q;
  logic               done_q;
  logic               ovalid_q;
  logic signed [13:0] norm_q;
  logic signed [15:0] lev_q;
  logic               neg_q, zspan_q;

  // one multiply per cycle over the five taps
  logic signed [31:0] mop;
  logic signed [18:0] mco;
  always_comb begin
    unique case (mi_q)
      3'd0: begin mco = cfg_i.b0; mop = 32'(x0_q); end
      3'd1: begin mco = cfg_i.b1; mop = 32'(xh1_q); end
      3'd2: begin mco = cfg_i.b2; mop = 32'(xh2_q); end
      3'd3: begin mco = -cfg_i.a1; mop = yh1_q; end
      default: begin mco = -cfg_i.a2; mop = yh2_q; end
    endcase
  end
  logic signed [63:0] mprod;
  logic signed [19:0] mco_x;
  assign mco_x = (mi_q == 3'd3) ? -{cfg_i.a1[18], cfg_i.a1} :
                 (mi_q == 3'd4) ? -{cfg_i.a2[18], cfg_i.a2} : {mco[18], mco};
  assign mprod = 64'(mco_x * mop);

  // round, saturate
  logic signed [63:0] racc;
  logic signed [47:0] yfl;
  logic signed [31:0] ysat;
  assign racc = acc_q + 64'sd32768;
  assign yfl = racc[63:16];
  assign ysat = (yfl > 48'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                (yfl < -48'sh80000000) ? -32'sh80000000 : yfl[31:0];

  // truncate toward zero
  logic signed [15:0] lev;
  assign lev = (ysat < 0 && ysat[15:0] != 16'd0) ? 16'(ysat[31:16] + 16'sd1)
                                                 : ysat[31:16];

  // tracking step
  logic signed [16:0] c17, hi_b, lo_b;
  logic signed [16:0] l17, p17;
  assign c17 = 17'(cfg_i.center);
  assign hi_b = c17 + 17'({5'd0, cfg_i.delta});
  assign lo_b = c17 - 17'({5'd0, cfg_i.delta});
  assign l17 = 17'(lev);
  assign p17 = 17'(plev_q);

  logic signed [15:0] ntlo, nthi;
  logic [3:0] nswc;
  phase_e nph;
  always_comb begin
    ntlo = tlo_q;
    nthi = thi_q;
    nswc = swc_q;
    nph = ph_q;
    if (trk_q) begin
      if (lev < tlo_q) ntlo = lev;
      if (lev > thi_q) nthi = lev;
      unique case (ph_q)
        PH_UP: if (l17 >= hi_b) begin nswc = swc_q + 4'd1; nph = PH_WAIT; end
        PH_DOWN: if (l17 <= lo_b) begin nswc = swc_q + 4'd1; nph = PH_WAIT; end
        default: begin
          if ((p17 <= c17 && l17 > c17) || (p17 >= c17 && l17 < c17))
            nph = (l17 > c17) ? PH_UP : PH_DOWN;
          else nph = PH_WAIT;
        end
      endcase
    end
  end
  logic win;
  assign win = nswc == 4'(SWINGS_PER_WINDOW);

  // divider: |2y - mid*65536| * NS*2 + span*65536 over span*131072
  localparam int DW = 56;
  logic [DW-1:0] dnum, dden, dq;
  logic ddone, dstart;
  logic signed [49:0] nbase;
  logic [49:0] nabs;
  assign nbase = 50'(y_q) * 50'sd2 - (50'(mid_q) <<< 16);
  assign nabs = nbase[49] ? 50'(-nbase) : 50'(nbase);
  assign dnum = (DW'(nabs) * DW'(2 * NORM_SCALE)) + (DW'(span_q[15:0]) << 16);
  assign dden = DW'(span_q[15:0]) << 17;
  assign dstart = (st_q == BK_TRACK);

  bqpt_div #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dq)
  );

  logic [DW-1:0] qlim;
  assign qlim = (dq > DW'(LimV)) ? DW'(LimV) : dq;

  always_comb begin
    st_d = st_q;
    q_pop_o = 1'b0;
    unique case (st_q)
      BK_IDLE: if (q_valid_i && !ovalid_q) begin st_d = BK_MUL; q_pop_o = 1'b1; end
      BK_MUL: st_d = (mi_q == 3'd4) ? BK_ACC : BK_MUL;
      BK_ACC: st_d = BK_TRACK;
      BK_TRACK: st_d = BK_DIV;
      BK_DIV: if (ddone) st_d = BK_OUT;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ovalid_q <= 1'b0;
      mi_q <= '0;
      xh1_q <= '0; xh2_q <= '0; yh1_q <= '0; yh2_q <= '0;
      tlo_q <= '0; thi_q <= '0;
      plo_q <= ResetLow; phi_q <= ResetHigh;
      mid_q <= '0; span_q <= 17'sd8190;
      plev_q <= '0; swc_q <= '0; ph_q <= PH_WAIT;
    end else begin
      st_q <= st_d;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (st_q)
        BK_IDLE: if (q_pop_o) begin
          mi_q <= '0;
          acc_q <= '0;
        end
        BK_MUL: begin
          acc_q <= acc_q + ((mi_q < 3'd3) ? (mprod <<< 16) : mprod);
          mi_q <= mi_q + 3'd1;
        end
        BK_ACC: begin
          y_q <= ysat;
          lev_q <= lev;
          xh2_q <= xh1_q; xh1_q <= x0_q;
          yh2_q <= yh1_q; yh1_q <= ysat;
          if (trk_q) plev_q <= lev;
          done_q <= win;
          if (win) begin
            mid_q <= trk_q ? 17'(ntlo) + 17'(nthi) : 17'(plo_q) + 17'(phi_q);
            span_q <= trk_q ? 17'(nthi) - 17'(ntlo) : 17'(phi_q) - 17'(plo_q);
            plo_q <= ntlo; phi_q <= nthi;
            tlo_q <= 16'(cfg_i.center); thi_q <= 16'(cfg_i.center);
            swc_q <= '0; ph_q <= PH_WAIT;
          end else begin
            if (!trk_q) begin
              mid_q <= 17'(plo_q) + 17'(phi_q);
              span_q <= 17'(phi_q) - 17'(plo_q);
            end
            tlo_q <= ntlo; thi_q <= nthi; swc_q <= nswc; ph_q <= nph;
          end
        end
        BK_TRACK: begin
          neg_q <= nbase[49];
          zspan_q <= span_q == 17'sd0;
        end
        BK_DIV: ;
        default: begin
          ovalid_q <= 1'b1;
          norm_q <= zspan_q ? 14'sd0 :
                    (neg_q ? -14'(qlim) : 14'(qlim));
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      x0_q <= q_item_i.sample;
      trk_q <= q_item_i.tracking;
    end
  end

  // tdata: normalized[13:0], filtered[29:14], window_done[30]
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {1'b0, done_q, lev_q, norm_q};
endmodule

// File: rtl/biquad_peak_track_normalizer.sv
// channel  | dir | contents
// s_axis   | in  | sample, speed
// m_axis   | out | normalized, filtered, window_done
// apb      | in  | eight coefficient and tracking registers
// Each beat runs five filter multiplies on one multiplier, then a 56-step
// restoring divider. A two-beat queue takes input while the back end
// works; a finished beat waits in the output register.
// Reset is asynchronous and loads register defaults and tracker state.
module biquad_peak_track_normalizer import bqpt_pkg::*; #(
  parameter int NORM_SCALE = NormScaleDef,
  parameter int SWINGS_PER_WINDOW = SwingsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample[12:0], speed[28:13]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // normalized[13:0], filtered[29:14], window_done[30]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t  cfg_q;
  logic  qv, qpop;
  item_t qitem;
  reg_idx_e ridx;
  assign ridx = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0 <= 19'sd65536; cfg_q.b1 <= '0; cfg_q.b2 <= '0;
      cfg_q.a1 <= '0; cfg_q.a2 <= '0; cfg_q.center <= '0;
      cfg_q.delta <= 12'd100; cfg_q.speed_thr <= 16'd1000;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_B0: cfg_q.b0 <= pwdata[18:0];
        REG_B1: cfg_q.b1 <= pwdata[18:0];
        REG_B2: cfg_q.b2 <= pwdata[18:0];
        REG_A1: cfg_q.a1 <= pwdata[18:0];
        REG_A2: cfg_q.a2 <= pwdata[18:0];
        REG_CENTER: cfg_q.center <= pwdata[12:0];
        REG_DELTA: cfg_q.delta <= pwdata[11:0];
        default: cfg_q.speed_thr <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_B0: prdata = 32'(unsigned'(cfg_q.b0));
      REG_B1: prdata = 32'(unsigned'(cfg_q.b1));
      REG_B2: prdata = 32'(unsigned'(cfg_q.b2));
      REG_A1: prdata = 32'(unsigned'(cfg_q.a1));
      REG_A2: prdata = 32'(unsigned'(cfg_q.a2));
      REG_CENTER: prdata = 32'(unsigned'(cfg_q.center));
      REG_DELTA: prdata = 32'(cfg_q.delta);
      default: prdata = 32'(cfg_q.speed_thr);
    endcase
  end

  bqpt_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .speed_thr_i(cfg_q.speed_thr), .q_valid_o(qv), .q_pop_i(qpop), .q_item_o(qitem)
  );

  bqpt_back #(.NORM_SCALE(NORM_SCALE), .SWINGS_PER_WINDOW(SWINGS_PER_WINDOW)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(qv), .q_pop_o(qpop), .q_item_i(qitem),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );
endmodule

// File: rtl/bqpt_checker.sv
module bqpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped while stalled");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("pad bit set");
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:0] != 14'h2000)
    else $error("normalized out of range");
  a_rdy: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule

bind biquad_peak_track_normalizer bqpt_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .pready
);
